>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// Each macro checks a property on the rising edge of clk; ASSERT_CLK holds it off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but also evaluated while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/jnfbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jnfbd_pkg;

  // Default sizes of the frame fields.
  localparam int DEF_ADDR_BITS  = 25;
  localparam int DEF_DATA_BITS  = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam int DEF_READ_WAIT  = 20;

  // Padding bits after each word of a burst write.
  localparam int BURST_PAD = 21;

  // Width of the command field.
  localparam int CMD_BITS = 4;

  localparam logic [CMD_BITS-1:0] OP_WRITE = 4'd1;
  localparam logic [CMD_BITS-1:0] OP_READ  = 4'd2;
  localparam logic [CMD_BITS-1:0] OP_BURST = 4'd4;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_WDATA  = 3'd2,
    PH_READ   = 3'd3,
    PH_COUNT  = 3'd4,
    PH_BWORD  = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

endpackage

`default_nettype wire

>>> hdl/jtag_nor_flash_bridge_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+--------------------------------------------
// in_       | input     | in_valid / in_ready   | tdi, shift_restart, flash_rdata
// out_      | output    | out_valid / out_ready | tdo, op_valid, op_write, op_addr, op_data
//
// Every request yields exactly one result, held in the result register from the cycle after it is accepted.
// A new request can be accepted every cycle while the output drains; the parser state and
// the result register are both updated at the accepting edge, so throughput is one bit per cycle.
// The input is ready whenever the result register is empty or is being drained,
// so a stalled output stops input after a single held result.
// Reset (rst_n low, synchronous) returns the parser to idle and empties the result register.

`include "assert_macros.svh"

module jtag_nor_flash_bridge_deframer #(
  parameter int ADDR_BITS  = jnfbd_pkg::DEF_ADDR_BITS,
  parameter int DATA_BITS  = jnfbd_pkg::DEF_DATA_BITS,
  parameter int COUNT_BITS = jnfbd_pkg::DEF_COUNT_BITS,
  parameter int READ_WAIT  = jnfbd_pkg::DEF_READ_WAIT
) (
  input  wire                  clk,
  input  wire                  rst_n,

  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_tdi,
  input  wire                  in_shift_restart,
  input  wire  [DATA_BITS-1:0] in_flash_rdata,

  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 out_tdo,
  output logic                 out_op_valid,
  output logic                 out_op_write,
  output logic [ADDR_BITS-1:0] out_op_addr,
  output logic [DATA_BITS-1:0] out_op_data
);

  // Last bit position of the header, read and burst word phases. The counter is sized for the longest one.
  localparam int HDR_END_I   = jnfbd_pkg::CMD_BITS + ADDR_BITS - 1;
  localparam int READ_END_I  = READ_WAIT + DATA_BITS;
  localparam int BWORD_END_I = DATA_BITS + jnfbd_pkg::BURST_PAD - 1;
  localparam int MAX_A       = (HDR_END_I > READ_END_I) ? HDR_END_I : READ_END_I;
  localparam int CNT_MAX     = (MAX_A > BWORD_END_I) ? MAX_A : BWORD_END_I;
  localparam int CNT_W       = $clog2(CNT_MAX + 1);

  localparam logic [CNT_W-1:0] CMD_END   = CNT_W'(jnfbd_pkg::CMD_BITS);
  localparam logic [CNT_W-1:0] HDR_END   = CNT_W'(HDR_END_I);
  localparam logic [CNT_W-1:0] DATA_END  = CNT_W'(DATA_BITS - 1);
  localparam logic [CNT_W-1:0] DATA_LEN  = CNT_W'(DATA_BITS);
  localparam logic [CNT_W-1:0] CAPTURE   = CNT_W'(READ_WAIT);
  localparam logic [CNT_W-1:0] READ_END  = CNT_W'(READ_END_I);
  localparam logic [CNT_W-1:0] COUNT_END = CNT_W'(COUNT_BITS - 1);
  localparam logic [CNT_W-1:0] BWORD_END = CNT_W'(BWORD_END_I);

  // Parser state.
  jnfbd_pkg::phase_t                   phase_r, phase_nxt;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt;
  logic [jnfbd_pkg::CMD_BITS-1:0]      cmd_r, cmd_nxt;
  logic [ADDR_BITS-1:0]                addr_r, addr_nxt;
  logic [DATA_BITS-1:0]                data_r, data_nxt;
  logic [COUNT_BITS-1:0]               words_r, words_nxt;
  logic [DATA_BITS-1:0]                rshift_r, rshift_nxt;

  // Result register.
  logic                                out_valid_r;
  logic                                tdo_r, tdo_nxt;
  logic                                ov_r, ov_nxt;
  logic                                ow_r, ow_nxt;
  logic [ADDR_BITS-1:0]                oa_r, oa_nxt;
  logic [DATA_BITS-1:0]                od_r, od_nxt;

  // Phase and position after a restart has been applied.
  jnfbd_pkg::phase_t                   ph;
  logic [CNT_W-1:0]                    cnt;
  logic                                in_fire;

  // Read phase conditions used by the checks at the end.
  logic                                rd_tail;
  logic                                rd_start;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    ph  = in_shift_restart ? jnfbd_pkg::PH_IDLE : phase_r;
    cnt = in_shift_restart ? '0 : cnt_r;

    phase_nxt  = ph;
    cnt_nxt    = cnt;
    cmd_nxt    = cmd_r;
    addr_nxt   = addr_r;
    data_nxt   = data_r;
    words_nxt  = words_r;
    rshift_nxt = rshift_r;

    tdo_nxt = 1'b0;
    ov_nxt  = 1'b0;
    ow_nxt  = 1'b0;
    oa_nxt  = '0;
    od_nxt  = '0;

    case (ph)
      jnfbd_pkg::PH_IDLE: begin
        // Leading zeros are skipped; a one is the start bit.
        if (in_tdi) begin
          cmd_nxt   = '0;
          addr_nxt  = '0;
          phase_nxt = jnfbd_pkg::PH_HEADER;
          cnt_nxt   = '0;
        end
      end
      jnfbd_pkg::PH_HEADER: begin
        // Command then address, both shifted in least significant bit first.
        if (cnt < CMD_END) begin
          cmd_nxt = {in_tdi, cmd_r[jnfbd_pkg::CMD_BITS-1:1]};
        end else begin
          addr_nxt = {in_tdi, addr_r[ADDR_BITS-1:1]};
        end
        if (cnt == HDR_END) begin
          cnt_nxt = '0;
          if (cmd_r == jnfbd_pkg::OP_WRITE) begin
            data_nxt  = '0;
            phase_nxt = jnfbd_pkg::PH_WDATA;
          end else if (cmd_r == jnfbd_pkg::OP_READ) begin
            ov_nxt    = 1'b1;
            oa_nxt    = addr_nxt;
            phase_nxt = jnfbd_pkg::PH_READ;
          end else if (cmd_r == jnfbd_pkg::OP_BURST) begin
            words_nxt = '0;
            phase_nxt = jnfbd_pkg::PH_COUNT;
          end else begin
            phase_nxt = jnfbd_pkg::PH_DONE;
          end
        end else begin
          cnt_nxt = cnt + CNT_W'(1);
        end
      end
      jnfbd_pkg::PH_WDATA: begin
        data_nxt = {in_tdi, data_r[DATA_BITS-1:1]};
        if (cnt == DATA_END) begin
          ov_nxt    = 1'b1;
          ow_nxt    = 1'b1;
          oa_nxt    = addr_r;
          od_nxt    = data_nxt;
          phase_nxt = jnfbd_pkg::PH_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt + CNT_W'(1);
        end
      end
      jnfbd_pkg::PH_READ: begin
        // Wait for the flash, capture its word, then return it on tdo.
        if (cnt == CAPTURE) begin
          rshift_nxt = in_flash_rdata;
        end else if (cnt > CAPTURE) begin
          tdo_nxt    = rshift_r[0];
          rshift_nxt = {1'b0, rshift_r[DATA_BITS-1:1]};
        end
        if (cnt >= READ_END) begin
          phase_nxt = jnfbd_pkg::PH_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt + CNT_W'(1);
        end
      end
      jnfbd_pkg::PH_COUNT: begin
        words_nxt = {in_tdi, words_r[COUNT_BITS-1:1]};
        if (cnt == COUNT_END) begin
          data_nxt  = '0;
          cnt_nxt   = '0;
          phase_nxt = (words_nxt == '0) ? jnfbd_pkg::PH_DONE : jnfbd_pkg::PH_BWORD;
        end else begin
          cnt_nxt = cnt + CNT_W'(1);
        end
      end
      jnfbd_pkg::PH_BWORD: begin
        if (cnt < DATA_LEN) begin
          data_nxt = {in_tdi, data_r[DATA_BITS-1:1]};
          if (cnt == DATA_END) begin
            ov_nxt   = 1'b1;
            ow_nxt   = 1'b1;
            oa_nxt   = addr_r;
            od_nxt   = data_nxt;
            addr_nxt = addr_r + ADDR_BITS'(1);
          end
        end
        if (cnt == BWORD_END) begin
          words_nxt = words_r - COUNT_BITS'(1);
          data_nxt  = '0;
          cnt_nxt   = '0;
          phase_nxt = (words_nxt == '0) ? jnfbd_pkg::PH_DONE : jnfbd_pkg::PH_BWORD;
        end else begin
          cnt_nxt = cnt + CNT_W'(1);
        end
      end
      jnfbd_pkg::PH_DONE: begin
        // Everything up to the next restart is ignored.
      end
      default: begin
        phase_nxt = jnfbd_pkg::PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= jnfbd_pkg::PH_IDLE;
      cnt_r       <= '0;
      cmd_r       <= '0;
      addr_r      <= '0;
      data_r      <= '0;
      words_r     <= '0;
      rshift_r    <= '0;
      out_valid_r <= 1'b0;
      tdo_r       <= 1'b0;
      ov_r        <= 1'b0;
      ow_r        <= 1'b0;
      oa_r        <= '0;
      od_r        <= '0;
    end else begin
      if (in_fire) begin
        phase_r  <= phase_nxt;
        cnt_r    <= cnt_nxt;
        cmd_r    <= cmd_nxt;
        addr_r   <= addr_nxt;
        data_r   <= data_nxt;
        words_r  <= words_nxt;
        rshift_r <= rshift_nxt;
        tdo_r    <= tdo_nxt;
        ov_r     <= ov_nxt;
        ow_r     <= ow_nxt;
        oa_r     <= oa_nxt;
        od_r     <= od_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tdo      = tdo_r;
  assign out_op_valid = ov_r;
  assign out_op_write = ow_r;
  assign out_op_addr  = oa_r;
  assign out_op_data  = od_r;

  assign rd_tail  = (phase_r == jnfbd_pkg::PH_READ) || (phase_r == jnfbd_pkg::PH_DONE);
  assign rd_start = (phase_r == jnfbd_pkg::PH_READ) && (cnt_r == '0);

  // With no operation issued, the operation fields must all be zero.
  `ASSERT_ALWAYS(a_idle_op_zero, !ov_r |-> (!ow_r && oa_r == '0 && od_r == '0), "op fields set")
  // Read data can only leave while the read phase runs or has just finished.
  `ASSERT_CLK(a_tdo_in_read, tdo_r |-> rd_tail, "tdo outside a read")
  // A read issue always starts the read phase from its first position.
  `ASSERT_CLK(a_read_starts, (ov_r && !ow_r) |-> rd_start, "read issued outside read start")

endmodule

`default_nettype wire
